// ===== rtl/tncur_pkg.sv =====
// Shared types and constants for the tiled n-dimensional cursor address block.
// Item structs, command and status between the controller and the datapath.
// No dependencies.
package tncur_pkg;

	localparam int DIV_W = 64;   // divider dividend width
	localparam int LEN_W = 7;    // holds a step count up to DIV_W
	localparam int POS_W = 44;   // signed linear position before truncation

	localparam logic [24:0] BLK_MAX = 25'h1FFFFFF;
	localparam logic [16:0] OFF_MAX = 17'h1FFFF;

	localparam logic [2:0] KIND_INIT   = 3'd0;
	localparam logic [2:0] KIND_PUT    = 3'd1;
	localparam logic [2:0] KIND_MOVE   = 3'd2;
	localparam logic [2:0] KIND_NEXT   = 3'd3;
	localparam logic [2:0] KIND_PREV   = 3'd4;
	localparam logic [2:0] KIND_SETPOS = 3'd5;
	localparam logic [2:0] KIND_READ   = 3'd6;

	localparam logic [2:0] CFG_DIM_COUNT     = 3'd0;
	localparam logic [2:0] CFG_DIM_LENGTHS   = 3'd1;
	localparam logic [2:0] CFG_TILE_LENGTHS  = 3'd2;
	localparam logic [2:0] CFG_TILE_STRIDES  = 3'd3;
	localparam logic [2:0] CFG_INNER_STRIDES = 3'd4;
	localparam logic [2:0] CFG_TILE_SIZE     = 3'd5;
	localparam logic [2:0] CFG_TOTAL_POINTS  = 3'd6;

	localparam logic [63:0] CFG_PACKED_RESET = 64'h0001_0001_0001_0001;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [15:0] coord_a;
		logic signed [15:0] coord_b;
		logic signed [15:0] coord_c;
		logic signed [15:0] coord_d;
		logic [1:0]         move_dim;
		logic signed [15:0] move_amount;
		logic [23:0]        set_position;
	} in_item_t;

	typedef struct packed {
		logic [24:0] out_block;
		logic [16:0] out_offset;
		logic [23:0] out_position;
		logic [15:0] point_a;
		logic [15:0] point_b;
		logic [15:0] point_c;
		logic [15:0] point_d;
		logic        at_limit;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_INIT,
		OP_DIV_MOD,
		OP_DIV_TILE,
		OP_MUL_B,
		OP_MUL_O,
		OP_ACC_O,
		OP_PUT_END,
		OP_POS_MUL,
		OP_POS_ADD,
		OP_STEP,
		OP_SETPOS,
		OP_GO_END,
		OP_REC_START,
		OP_DIV_RB,
		OP_DIV_RO,
		OP_REC_MUL,
		OP_REC_SUM,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] dim;
	} dp_cmd_t;

	typedef struct packed {
		logic       div_busy;
		logic [2:0] d_used;
		logic       step_go;
		logic       out_busy;
	} dp_status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INIT,
		S_PM_GO,
		S_PM_W,
		S_PT_W,
		S_MUL_O,
		S_ACC_O,
		S_PUT_END,
		S_POS_MUL,
		S_POS_ADD,
		S_STEP,
		S_SETPOS,
		S_GO_W,
		S_REC_START,
		S_RB_GO,
		S_RB_W,
		S_RO_W,
		S_REC_SUM,
		S_OMUL,
		S_OADD,
		S_EMIT
	} ctrl_state_t;

	function automatic logic [15:0] field16(input logic [63:0] r, input logic [1:0] k);
		return r[16*k +: 16];
	endfunction

endpackage

// ===== rtl/tncur_div.sv =====
// Restoring divider, one quotient bit per cycle, variable step count.
// A zero divisor gives quotient 0 and the dividend as remainder.
// Depends on tncur_pkg.
module tncur_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tncur_pkg::DIV_W-1:0] dividend,
	input  logic [16:0]                 divisor,
	input  logic [tncur_pkg::LEN_W-1:0] len,
	output logic                        busy,
	output logic [tncur_pkg::DIV_W-1:0] quotient,
	output logic [tncur_pkg::DIV_W-1:0] remainder
);
	import tncur_pkg::*;

	logic [LEN_W-1:0] cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dvd_q;
	logic [16:0]      rem_q;
	logic [16:0]      dsr_q;
	logic             dz_q;
	logic [17:0]      trial;
	logic             ge;
	logic [16:0]      step_rem;

	assign trial    = {rem_q, quo_q[DIV_W-1]};
	assign ge       = trial >= {1'b0, dsr_q};
	assign step_rem = ge ? 17'(trial - {1'b0, dsr_q}) : trial[16:0];
	assign busy     = cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= len;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// dividend is left-aligned so that only len steps are needed
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend << (LEN_W'(DIV_W) - len);
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
			dz_q  <= divisor == '0;
		end else if (busy) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= step_rem;
		end
	end

	assign quotient  = dz_q ? '0 : quo_q;
	assign remainder = dz_q ? dvd_q : {{(DIV_W-17){1'b0}}, rem_q};

endmodule

// ===== rtl/tncur_dp.sv =====
// Datapath: configuration registers, cursor state, shared multiplier, divider.
// Executes one command from the controller each cycle.
// Depends on tncur_pkg and tncur_div.
module tncur_dp #(
	parameter int MAX_DIMS   = 4,
	parameter int COORD_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [63:0]            cfg_data,
	input  tncur_pkg::in_item_t    in_data,
	input  tncur_pkg::dp_cmd_t     cmd,
	output tncur_pkg::dp_status_t  status,
	output logic                   out_valid,
	input  logic                   out_ready,
	output tncur_pkg::out_item_t   out_data
);
	import tncur_pkg::*;

	localparam int NUSED = (MAX_DIMS < 4) ? MAX_DIMS : 4;
	localparam int CW    = (COORD_BITS > 16) ? COORD_BITS : 16;
	localparam int XW    = CW + 2;

	// configuration
	logic [2:0]  dim_count_q;
	logic [63:0] dim_len_q, tile_len_q, tile_str_q, inner_str_q;
	logic [16:0] tile_size_q;
	logic [24:0] total_q;

	// cursor state
	logic [24:0]           blk_q;
	logic [16:0]           off_q;
	logic [COORD_BITS-1:0] pt_q [4];
	logic                  limit_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	// scratch
	in_item_t               in_q;
	logic [34:0]            acc_b_q, acc_o_q;
	logic signed [51:0]     prod_q;
	logic signed [POS_W-1:0] p_q;
	logic [DIV_W-1:0]       rb_q;
	logic [16:0]            ro_q;
	logic [COORD_BITS-1:0]  bq_q, oq_q;
	logic                   neg_q;
	logic [15:0]            r_tile_q;

	logic [2:0]  d_used;
	logic [16:0] tsz;
	logic [1:0]  k;
	logic [15:0] l_k, tl_k, ts_k, is_k;

	logic signed [XW-1:0] x_val, cp_s, m_s, coord_s;
	logic [XW-2:0]        ax;
	logic [15:0]          z_fix;

	logic signed [POS_W-1:0] pm2;
	logic                    step_go, step_limit;
	logic [DIV_W-1:0]        step_dvd;
	logic signed [25:0]      blkm1;

	logic               div_start, div_busy;
	logic [DIV_W-1:0]   div_dvd, div_quo, div_rem;
	logic [16:0]        div_dsr;
	logic [LEN_W-1:0]   div_len;

	logic signed [33:0] mul_a;
	logic signed [17:0] mul_b;

	assign d_used = (dim_count_q > 3'(NUSED)) ? 3'(NUSED) : dim_count_q;
	assign tsz    = (tile_size_q == '0) ? 17'd1 : tile_size_q;
	assign k      = cmd.dim;
	assign l_k    = field16(dim_len_q, k);
	assign tl_k   = (field16(tile_len_q, k) == '0) ? 16'd1 : field16(tile_len_q, k);
	assign ts_k   = field16(tile_str_q, k);
	assign is_k   = field16(inner_str_q, k);

	// zero-based coordinate before wrapping
	always_comb begin
		case (k)
			2'd0:    coord_s = XW'(in_q.coord_a);
			2'd1:    coord_s = XW'(in_q.coord_b);
			2'd2:    coord_s = XW'(in_q.coord_c);
			default: coord_s = XW'(in_q.coord_d);
		endcase
	end
	assign cp_s  = $signed({{(XW-COORD_BITS){1'b0}}, pt_q[k]});
	assign m_s   = (in_q.move_dim == k) ? XW'(in_q.move_amount) : '0;
	assign x_val = (in_q.kind == KIND_MOVE) ? (cp_s + m_s - XW'(1)) : (coord_s - XW'(1));
	assign ax    = x_val[XW-1] ? (XW-1)'(-x_val) : x_val[XW-2:0];

	// truncating remainder turned into a floored modulo
	always_comb begin
		if (l_k == '0)
			z_fix = '0;
		else if (neg_q && div_rem[15:0] != '0)
			z_fix = l_k - div_rem[15:0];
		else
			z_fix = div_rem[15:0];
	end

	assign blkm1 = $signed({1'b0, blk_q}) - 26'sd1;
	assign pm2   = p_q - POS_W'(2);

	always_comb begin
		if (in_q.kind == KIND_NEXT) begin
			step_go    = !p_q[POS_W-1] && (p_q < $signed({{(POS_W-25){1'b0}}, total_q}));
			step_limit = !step_go;
			step_dvd   = {{(DIV_W-POS_W){1'b0}}, p_q};
		end else begin
			step_go    = !pm2[POS_W-1];
			step_limit = pm2[POS_W-1] || (pm2 == '0);
			step_dvd   = {{(DIV_W-POS_W){1'b0}}, pm2};
		end
	end

	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dsr   = '0;
		div_len   = '0;
		case (cmd.op)
			OP_DIV_MOD: begin
				div_start = 1'b1;
				div_dvd   = {{(DIV_W-XW+1){1'b0}}, ax};
				div_dsr   = {1'b0, l_k};
				div_len   = LEN_W'(XW-1);
			end
			OP_DIV_TILE: begin
				div_start = 1'b1;
				div_dvd   = {{(DIV_W-16){1'b0}}, z_fix};
				div_dsr   = {1'b0, tl_k};
				div_len   = LEN_W'(16);
			end
			OP_STEP: begin
				div_start = step_go;
				div_dvd   = step_dvd;
				div_dsr   = tsz;
				div_len   = LEN_W'(POS_W);
			end
			OP_SETPOS: begin
				div_start = 1'b1;
				div_dvd   = {{(DIV_W-24){1'b0}}, in_q.set_position};
				div_dsr   = tsz;
				div_len   = LEN_W'(24);
			end
			OP_DIV_RB: begin
				div_start = 1'b1;
				div_dvd   = rb_q;
				div_dsr   = {1'b0, ts_k};
				div_len   = (|rb_q[DIV_W-1:25]) ? LEN_W'(DIV_W) : LEN_W'(25);
			end
			OP_DIV_RO: begin
				div_start = 1'b1;
				div_dvd   = {{(DIV_W-17){1'b0}}, ro_q};
				div_dsr   = {1'b0, is_k};
				div_len   = LEN_W'(17);
			end
			default: ;
		endcase
	end

	tncur_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.len       (div_len),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// one shared multiplier, operands chosen by the command
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_B: begin
				mul_a = $signed({18'b0, div_quo[15:0]});
				mul_b = $signed({2'b0, ts_k});
			end
			OP_MUL_O: begin
				mul_a = $signed({18'b0, r_tile_q});
				mul_b = $signed({2'b0, is_k});
			end
			OP_POS_MUL: begin
				mul_a = 34'(blkm1);
				mul_b = $signed({1'b0, tsz});
			end
			OP_REC_MUL: begin
				mul_a = $signed({{(34-COORD_BITS){1'b0}}, bq_q});
				mul_b = $signed({2'b0, tl_k});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= 3'd1;
			dim_len_q   <= CFG_PACKED_RESET;
			tile_len_q  <= CFG_PACKED_RESET;
			tile_str_q  <= CFG_PACKED_RESET;
			inner_str_q <= CFG_PACKED_RESET;
			tile_size_q <= 17'd1;
			total_q     <= 25'd1;
			blk_q       <= 25'd1;
			off_q       <= 17'd1;
			for (int i = 0; i < 4; i++) pt_q[i] <= COORD_BITS'(1);
			limit_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DIM_COUNT:     dim_count_q <= cfg_data[2:0];
					CFG_DIM_LENGTHS:   dim_len_q   <= cfg_data;
					CFG_TILE_LENGTHS:  tile_len_q  <= cfg_data;
					CFG_TILE_STRIDES:  tile_str_q  <= cfg_data;
					CFG_INNER_STRIDES: inner_str_q <= cfg_data;
					CFG_TILE_SIZE:     tile_size_q <= cfg_data[16:0];
					CFG_TOTAL_POINTS:  total_q     <= cfg_data[24:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_EMIT)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (cmd.op)
				OP_LOAD: limit_q <= 1'b0;
				OP_INIT: begin
					blk_q <= 25'd1;
					off_q <= 17'd1;
				end
				OP_PUT_END: begin
					blk_q <= (acc_b_q > 35'(BLK_MAX)) ? BLK_MAX : acc_b_q[24:0];
					off_q <= (acc_o_q > 35'(OFF_MAX)) ? OFF_MAX : acc_o_q[16:0];
				end
				OP_STEP: limit_q <= step_limit;
				OP_GO_END: begin
					blk_q <= div_quo[24:0] + 25'd1;
					off_q <= div_rem[16:0] + 17'd1;
				end
				OP_REC_START: for (int i = 0; i < 4; i++) pt_q[i] <= COORD_BITS'(1);
				OP_REC_SUM:   pt_q[k] <= prod_q[COORD_BITS-1:0] + oq_q + COORD_BITS'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				in_q    <= in_data;
				acc_b_q <= 35'd1;
				acc_o_q <= 35'd1;
			end
			OP_DIV_MOD: neg_q <= x_val[XW-1];
			OP_MUL_B: begin
				prod_q   <= mul_a * mul_b;
				r_tile_q <= div_rem[15:0];
			end
			OP_MUL_O: begin
				acc_b_q <= acc_b_q + {3'b0, prod_q[31:0]};
				prod_q  <= mul_a * mul_b;
			end
			OP_ACC_O:   acc_o_q <= acc_o_q + {3'b0, prod_q[31:0]};
			OP_POS_MUL: prod_q  <= mul_a * mul_b;
			OP_POS_ADD: p_q     <= prod_q[POS_W-1:0] + {{(POS_W-17){1'b0}}, off_q};
			OP_REC_START: begin
				// tile number zero stands for one below zero, all ones
				rb_q <= (blk_q == '0) ? '1 : {{(DIV_W-25){1'b0}}, 25'(blk_q - 25'd1)};
				ro_q <= off_q - 17'd1;
			end
			OP_DIV_RO: begin
				bq_q <= div_quo[COORD_BITS-1:0];
				rb_q <= div_rem;
			end
			OP_REC_MUL: begin
				prod_q <= mul_a * mul_b;
				oq_q   <= div_quo[COORD_BITS-1:0];
				ro_q   <= div_rem[16:0];
			end
			OP_EMIT: begin
				out_q.out_block    <= blk_q;
				out_q.out_offset   <= off_q;
				out_q.out_position <= 24'(p_q[23:0] - 24'd1);
				out_q.point_a      <= (3'd0 < d_used) ? 16'(pt_q[0]) : 16'd0;
				out_q.point_b      <= (3'd1 < d_used) ? 16'(pt_q[1]) : 16'd0;
				out_q.point_c      <= (3'd2 < d_used) ? 16'(pt_q[2]) : 16'd0;
				out_q.point_d      <= (3'd3 < d_used) ? 16'(pt_q[3]) : 16'd0;
				out_q.at_limit     <= limit_q;
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign out_data        = out_q;
	assign status.div_busy = div_busy;
	assign status.d_used   = d_used;
	assign status.step_go  = step_go;
	assign status.out_busy = out_valid_q && !out_ready;

`ifndef SYNTH
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT) |-> !(out_valid_q && !out_ready))
		else $error("result overwritten before transfer");
	a_put_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_PUT_END) |=> (blk_q != '0 && off_q != '0))
		else $error("put left a zero tile or offset");
`endif

endmodule

// ===== rtl/tncur_ctrl.sv =====
// Controller: sequences the datapath through put, step, jump and recovery.
// Holds the dimension counter; talks to the datapath by command and status.
// Depends on tncur_pkg.
module tncur_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [2:0]            in_kind,
	output logic                  in_ready,
	input  tncur_pkg::dp_status_t status,
	output tncur_pkg::dp_cmd_t    cmd
);
	import tncur_pkg::*;

	ctrl_state_t state_q, state_d;
	logic [1:0]  k_q, k_d;
	logic [1:0]  k_last;

	assign k_last = 2'(status.d_used - 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.dim  = k_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					k_d    = '0;
					case (in_kind)
						KIND_INIT:   state_d = S_INIT;
						KIND_PUT,
						KIND_MOVE:   state_d = (status.d_used == '0) ? S_PUT_END : S_PM_GO;
						KIND_NEXT,
						KIND_PREV:   state_d = S_POS_MUL;
						KIND_SETPOS: state_d = S_SETPOS;
						default:     state_d = S_REC_START;
					endcase
				end
			end
			S_INIT: begin
				cmd.op  = OP_INIT;
				state_d = S_REC_START;
			end
			S_PM_GO: begin
				cmd.op  = OP_DIV_MOD;
				state_d = S_PM_W;
			end
			S_PM_W: begin
				if (!status.div_busy) begin
					cmd.op  = OP_DIV_TILE;
					state_d = S_PT_W;
				end
			end
			S_PT_W: begin
				if (!status.div_busy) begin
					cmd.op  = OP_MUL_B;
					state_d = S_MUL_O;
				end
			end
			S_MUL_O: begin
				cmd.op  = OP_MUL_O;
				state_d = S_ACC_O;
			end
			S_ACC_O: begin
				cmd.op = OP_ACC_O;
				if (k_q == k_last) begin
					state_d = S_PUT_END;
				end else begin
					k_d     = k_q + 2'd1;
					state_d = S_PM_GO;
				end
			end
			S_PUT_END: begin
				cmd.op  = OP_PUT_END;
				state_d = S_REC_START;
			end
			S_POS_MUL: begin
				cmd.op  = OP_POS_MUL;
				state_d = S_POS_ADD;
			end
			S_POS_ADD: begin
				cmd.op  = OP_POS_ADD;
				state_d = S_STEP;
			end
			S_STEP: begin
				cmd.op  = OP_STEP;
				state_d = status.step_go ? S_GO_W : S_REC_START;
			end
			S_SETPOS: begin
				cmd.op  = OP_SETPOS;
				state_d = S_GO_W;
			end
			S_GO_W: begin
				if (!status.div_busy) begin
					cmd.op  = OP_GO_END;
					state_d = S_REC_START;
				end
			end
			S_REC_START: begin
				cmd.op = OP_REC_START;
				if (status.d_used == '0) begin
					state_d = S_OMUL;
				end else begin
					k_d     = k_last;
					state_d = S_RB_GO;
				end
			end
			S_RB_GO: begin
				cmd.op  = OP_DIV_RB;
				state_d = S_RB_W;
			end
			S_RB_W: begin
				if (!status.div_busy) begin
					cmd.op  = OP_DIV_RO;
					state_d = S_RO_W;
				end
			end
			S_RO_W: begin
				if (!status.div_busy) begin
					cmd.op  = OP_REC_MUL;
					state_d = S_REC_SUM;
				end
			end
			S_REC_SUM: begin
				cmd.op = OP_REC_SUM;
				if (k_q == '0) begin
					state_d = S_OMUL;
				end else begin
					k_d     = k_q - 2'd1;
					state_d = S_RB_GO;
				end
			end
			S_OMUL: begin
				cmd.op  = OP_POS_MUL;
				state_d = S_OADD;
			end
			S_OADD: begin
				cmd.op  = OP_POS_ADD;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!status.out_busy) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

`ifndef SYNTH
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transfer taken while an item is in work");
`endif

endmodule

// ===== rtl/tiled_ndim_cursor_address_core.sv =====
// Top level of the tiled n-dimensional cursor address block.
// Instantiates the controller and the datapath. Depends on tncur_pkg, tncur_ctrl and tncur_dp.
//
// Usage:
//   in_valid/in_ready/in_data carry one command; out_valid/out_ready/out_data
//   carry its single answer (tile, offset, linear position, coordinates, limit).
//   cfg_we/cfg_index/cfg_data write a configuration register at once; write
//   only while no command is in work.
//   One command is worked at a time. It is served by the shared
//   one-bit-per-cycle divider, visited serially per dimension:
//     put or move : per dimension a modulo by the length and a divide by
//                   the tile length, then recovery;
//     next, prev  : multiply, add and step, plus a divide when the cursor moves;
//     set position: one divide; init and read none; then recovery.
//   Recovery divides by the tile and inner strides per dimension, outermost first
//   (full width when the tile number has wrapped to zero), then the answer is emitted.
//   The answer sits in an output register; the next command is accepted
//   once it has been loaded, even while the receiver stalls. A further answer
//   waits until the held one has been transferred.
//   Reset puts the cursor at the origin and the registers at one dimension
//   with all lengths, strides and sizes one.
module tiled_ndim_cursor_address_core #(
	parameter int MAX_DIMS   = 4,
	parameter int COORD_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tncur_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tncur_pkg::out_item_t out_data
);
	import tncur_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	tncur_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_kind  (in_data.kind),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	tncur_dp #(
		.MAX_DIMS   (MAX_DIMS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for tiled_ndim_cursor_address_core: directed and random commands checked
// against an in-bench cursor predictor, with random stalls on both channels.
// Depends on tncur_pkg and the core RTL.
module tb_top;
	import tncur_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 700;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	tiled_ndim_cursor_address_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #4 clk = ~clk;

	// predictor copy of configuration and cursor
	bit [2:0] cf_dims;
	bit [63:0] cf_len, cf_tlen, cf_tstr, cf_istr;
	bit [16:0] cf_tsize;
	bit [24:0] cf_total;
	bit [63:0] cur_blk, cur_off;
	bit [15:0] cur_pt [4];

	out_item_t expected_answers [$];
	int n_err = 0;
	bit quiet = 1'b0;
	bit no_gaps = 1'b0;
	int hold_cnt = 0;

	function automatic bit [63:0] lane(bit [63:0] r, int i);
		return {48'd0, r[16*i +: 16]};
	endfunction

	function automatic int dims_in_use();
		return (cf_dims > 3'd4) ? 4 : int'(cf_dims);
	endfunction

	function automatic bit [63:0] tile_len(int i);
		bit [63:0] p;
		p = lane(cf_tlen, i);
		return (p != 0) ? p : 64'd1;
	endfunction

	function automatic bit [63:0] tile_pts();
		return (cf_tsize != 0) ? {47'd0, cf_tsize} : 64'd1;
	endfunction

	function automatic void place_point(longint c [4]);
		bit [63:0] blk, off, z, p;
		longint l, t;
		int d;
		d = dims_in_use();
		blk = 1;
		off = 1;
		for (int i = 0; i < d; i++) begin
			l = longint'(lane(cf_len, i));
			z = 0;
			p = tile_len(i);
			if (l != 0) begin
				t = (c[i] - 1) % l;
				if (t < 0) t += l;
				z = t;
			end
			blk += (z / p) * lane(cf_tstr, i);
			off += (z % p) * lane(cf_istr, i);
		end
		cur_blk = (blk > 64'h1FFFFFF) ? 64'h1FFFFFF : blk;
		cur_off = (off > 64'h1FFFF) ? 64'h1FFFF : off;
	endfunction

	function automatic void jump_to(bit [63:0] pos);
		cur_blk = (pos / tile_pts() + 1) & 64'h1FFFFFF;
		cur_off = (pos % tile_pts() + 1) & 64'h1FFFF;
	endfunction

	// coordinates from tile and offset, outermost dimension first
	function automatic void recover_coords();
		bit [63:0] rb, ro, s, o, bq, oq, sum;
		rb = cur_blk - 1;
		ro = cur_off - 1;
		for (int i = 0; i < 4; i++) cur_pt[i] = 16'd1;
		for (int k = dims_in_use() - 1; k >= 0; k--) begin
			s = lane(cf_tstr, k);
			o = lane(cf_istr, k);
			bq = (s != 0) ? rb / s : 0;
			oq = (o != 0) ? ro / o : 0;
			rb -= bq * s;
			ro -= oq * o;
			sum = bq * tile_len(k) + oq + 1;
			cur_pt[k] = sum[15:0];
		end
	endfunction

	function automatic out_item_t cursor_answer(in_item_t it);
		out_item_t r;
		longint c [4];
		bit [63:0] pos;
		longint spos;
		bit lim;
		lim = 1'b0;
		case (it.kind)
			KIND_INIT: begin
				cur_blk = 1;
				cur_off = 1;
			end
			KIND_PUT: begin
				c[0] = longint'(it.coord_a);
				c[1] = longint'(it.coord_b);
				c[2] = longint'(it.coord_c);
				c[3] = longint'(it.coord_d);
				place_point(c);
			end
			KIND_MOVE: begin
				for (int i = 0; i < 4; i++)
					c[i] = longint'({48'd0, cur_pt[i]})
						+ ((i == int'(it.move_dim)) ? longint'(it.move_amount) : 64'sd0);
				place_point(c);
			end
			KIND_NEXT: begin
				pos = (cur_blk - 1) * tile_pts() + cur_off;
				if (pos >= {39'd0, cf_total}) lim = 1'b1;
				else jump_to(pos);
			end
			KIND_PREV: begin
				pos = (cur_blk - 1) * tile_pts() + cur_off;
				spos = $signed(pos) - 2;
				if (spos <= 0) lim = 1'b1;
				if (spos >= 0) jump_to(spos);
			end
			KIND_SETPOS: jump_to({40'd0, it.set_position});
			default: ;
		endcase
		recover_coords();
		pos = (cur_blk - 1) * tile_pts() + cur_off - 1;
		r.out_block = cur_blk[24:0];
		r.out_offset = cur_off[16:0];
		r.out_position = pos[23:0];
		r.point_a = (dims_in_use() > 0) ? cur_pt[0] : 16'd0;
		r.point_b = (dims_in_use() > 1) ? cur_pt[1] : 16'd0;
		r.point_c = (dims_in_use() > 2) ? cur_pt[2] : 16'd0;
		r.point_d = (dims_in_use() > 3) ? cur_pt[3] : 16'd0;
		r.at_limit = lim;
		return r;
	endfunction

	// ---------------- drivers ----------------
	task automatic write_reg(logic [2:0] idx, logic [63:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			CFG_DIM_COUNT:     cf_dims = v[2:0];
			CFG_DIM_LENGTHS:   cf_len = v;
			CFG_TILE_LENGTHS:  cf_tlen = v;
			CFG_TILE_STRIDES:  cf_tstr = v;
			CFG_INNER_STRIDES: cf_istr = v;
			CFG_TILE_SIZE:     cf_tsize = v[16:0];
			CFG_TOTAL_POINTS:  cf_total = v[24:0];
			default: ;
		endcase
	endtask

	task automatic apply_cfg(logic [63:0] dims, logic [63:0] len, logic [63:0] tl,
			logic [63:0] ts, logic [63:0] is, logic [63:0] tsz, logic [63:0] tot);
		write_reg(CFG_DIM_COUNT, dims);
		write_reg(CFG_DIM_LENGTHS, len);
		write_reg(CFG_TILE_LENGTHS, tl);
		write_reg(CFG_TILE_STRIDES, ts);
		write_reg(CFG_INNER_STRIDES, is);
		write_reg(CFG_TILE_SIZE, tsz);
		write_reg(CFG_TOTAL_POINTS, tot);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_cmd(in_item_t it);
		if (!quiet && !no_gaps && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 2)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		expected_answers.push_back(cursor_answer(it));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_answers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic in_item_t cmd(logic [2:0] k, logic [15:0] a, logic [15:0] b,
			logic [1:0] md, logic [15:0] amt, logic [23:0] sp);
		in_item_t it;
		it = '0;
		it.kind = k;
		it.coord_a = a;
		it.coord_b = b;
		it.coord_c = 16'd1;
		it.coord_d = 16'd1;
		it.move_dim = md;
		it.move_amount = amt;
		it.set_position = sp;
		return it;
	endfunction

	function automatic logic [15:0] pick_coord(int i);
		int l;
		l = int'(lane(cf_len, i));
		if ($urandom_range(0, 4) == 0) return 16'($urandom);
		return 16'($urandom_range(1, (l == 0) ? 4 : l));
	endfunction

	function automatic in_item_t random_cmd();
		in_item_t it;
		int w;
		it = '0;
		it.move_dim = 2'($urandom);
		it.move_amount = 16'($urandom);
		it.set_position = 24'($urandom);
		w = $urandom_range(0, 99);
		if (w < 5) it.kind = KIND_INIT;
		else if (w < 30) it.kind = KIND_PUT;
		else if (w < 55) it.kind = KIND_MOVE;
		else if (w < 70) it.kind = KIND_NEXT;
		else if (w < 85) it.kind = KIND_PREV;
		else if (w < 93) it.kind = KIND_SETPOS;
		else it.kind = ($urandom_range(0, 1) != 0) ? KIND_READ : 3'd7;
		it.coord_a = pick_coord(0);
		it.coord_b = pick_coord(1);
		it.coord_c = pick_coord(2);
		it.coord_d = pick_coord(3);
		if ($urandom_range(0, 3) != 0) it.move_amount = 16'($urandom_range(0, 6) - 3);
		if ($urandom_range(0, 3) != 0 && cf_total != 0)
			it.set_position = 24'($urandom_range(0, int'(cf_total) - 1));
		return it;
	endfunction

	// mostly consistent mixed-radix layouts, sometimes raw noise
	task automatic random_cfg();
		logic [63:0] len, tl, ts, is;
		int d, l, t, n, tstride, istride;
		if ($urandom_range(0, 3) == 0) begin
			apply_cfg(64'($urandom_range(0, 7)), {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom},
				64'($urandom_range(0, 17'h1FFFF)), 64'($urandom_range(0, 25'h1FFFFFF)));
		end else begin
			d = int'($urandom_range(1, 4));
			tstride = 1;
			istride = 1;
			for (int i = 0; i < 4; i++) begin
				l = int'($urandom_range(1, 10));
				t = int'($urandom_range(1, l));
				n = (l + t - 1) / t;
				len[16*i +: 16] = 16'(l);
				tl[16*i +: 16] = 16'(t);
				ts[16*i +: 16] = 16'(tstride);
				is[16*i +: 16] = 16'(istride);
				if (i < d) begin
					tstride *= n;
					istride *= t;
				end
			end
			apply_cfg(64'(d), len, tl, ts, is, 64'(istride), 64'(tstride * istride));
		end
	endtask

	// ---------------- tests ----------------
	task automatic test_reset_state();
		send_cmd(cmd(KIND_READ, 16'd1, 16'd1, 2'd0, 16'd0, 24'd0));
		send_cmd(cmd(KIND_INIT, 16'd1, 16'd1, 2'd0, 16'd0, 24'd0));
		drain();
	endtask

	task automatic test_small_grid();
		// 5x4 points in 2x2 tiles, 3x2 tiles
		apply_cfg(64'd2, 64'h0001_0001_0004_0005, 64'h0001_0001_0002_0002,
			64'h0001_0001_0003_0001, 64'h0001_0001_0002_0001, 64'd4, 64'd24);
		send_cmd(cmd(KIND_PUT, 16'd1, 16'd1, 2'd0, 16'd0, 24'd0));
		send_cmd(cmd(KIND_PUT, 16'h8000, 16'h7FFF, 2'd0, 16'd0, 24'd0));
		send_cmd(cmd(KIND_PUT, 16'd0, 16'd0, 2'd0, 16'd0, 24'd0));
		send_cmd(cmd(KIND_MOVE, 16'd0, 16'd0, 2'd0, 16'd1, 24'd0));
		send_cmd(cmd(KIND_MOVE, 16'd0, 16'd0, 2'd3, 16'd5, 24'd0));
		send_cmd(cmd(KIND_MOVE, 16'd0, 16'd0, 2'd1, 16'h8000, 24'd0));
		send_cmd(cmd(KIND_SETPOS, 16'd0, 16'd0, 2'd0, 16'd0, 24'd1));
		send_cmd(cmd(KIND_NEXT, 16'd0, 16'd0, 2'd0, 16'd0, 24'd0));
		send_cmd(cmd(KIND_PREV, 16'd0, 16'd0, 2'd0, 16'd0, 24'd0));
		send_cmd(cmd(KIND_PREV, 16'd0, 16'd0, 2'd0, 16'd0, 24'd0));
		send_cmd(cmd(KIND_SETPOS, 16'd0, 16'd0, 2'd0, 16'd0, 24'd23));
		send_cmd(cmd(KIND_NEXT, 16'd0, 16'd0, 2'd0, 16'd0, 24'd0));
		send_cmd(cmd(KIND_SETPOS, 16'd0, 16'd0, 2'd0, 16'd0, 24'hFFFFFF));
		send_cmd(cmd(3'd7, 16'd0, 16'd0, 2'd0, 16'd0, 24'd0));
		drain();
	endtask

	task automatic test_saturation();
		// large strides saturate tile and offset; prev then wraps the tile number
		apply_cfg(64'd7, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0100,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'h1FFFFFF);
		send_cmd(cmd(KIND_PUT, 16'hFFFF, 16'hFFFF, 2'd0, 16'd0, 24'd0));
		send_cmd(cmd(KIND_PREV, 16'd0, 16'd0, 2'd0, 16'd0, 24'd0));
		send_cmd(cmd(KIND_NEXT, 16'd0, 16'd0, 2'd0, 16'd0, 24'd0));
		send_cmd(cmd(KIND_READ, 16'd0, 16'd0, 2'd0, 16'd0, 24'd0));
		drain();
	endtask

	task automatic test_degenerate();
		// no dimensions, zero lengths and strides, a tile of 0x10000 points
		apply_cfg(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'h10000, 64'd0);
		send_cmd(cmd(KIND_PUT, 16'd3, 16'd3, 2'd0, 16'd0, 24'd0));
		send_cmd(cmd(KIND_NEXT, 16'd0, 16'd0, 2'd0, 16'd0, 24'd0));
		send_cmd(cmd(KIND_PREV, 16'd0, 16'd0, 2'd0, 16'd0, 24'd0));
		send_cmd(cmd(KIND_SETPOS, 16'd0, 16'd0, 2'd0, 16'd0, 24'h123456));
		send_cmd(cmd(KIND_MOVE, 16'd0, 16'd0, 2'd2, 16'h7FFF, 24'd0));
		drain();
	endtask

	task automatic test_backpressure();
		// receiver holds off while commands keep coming
		random_cfg();
		no_gaps = 1'b1;
		hold_cnt = 400;
		repeat (12) send_cmd(random_cmd());
		no_gaps = 1'b0;
		drain();
	endtask

	task automatic test_sender_pause();
		random_cfg();
		repeat (20) send_cmd(random_cmd());
		drain();
		repeat (20) send_cmd(random_cmd());
		drain();
	endtask

	task automatic test_random(int phases, int per_phase);
		for (int p = 0; p < phases; p++) begin
			random_cfg();
			repeat (per_phase) send_cmd(random_cmd());
			drain();
		end
	endtask

	// ---------------- receiver, checker, watchdog ----------------
	int stall_left = 0;
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
		if (exp !== act) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			n_err++;
		end
	endtask

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_answers.size() == 0) begin
				$error("unexpected answer transfer %h", out_data);
				n_err++;
			end else begin
				e = expected_answers.pop_front();
				check_field("out_block", 64'(e.out_block), 64'(out_data.out_block));
				check_field("out_offset", 64'(e.out_offset), 64'(out_data.out_offset));
				check_field("out_position", 64'(e.out_position),
					64'(out_data.out_position));
				check_field("point_a", 64'(e.point_a), 64'(out_data.point_a));
				check_field("point_b", 64'(e.point_b), 64'(out_data.point_b));
				check_field("point_c", 64'(e.point_c), 64'(out_data.point_c));
				check_field("point_d", 64'(e.point_d), 64'(out_data.point_d));
				check_field("at_limit", 64'(e.at_limit), 64'(out_data.at_limit));
			end
		end
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		cf_dims = 1;
		cf_len = CFG_PACKED_RESET;
		cf_tlen = CFG_PACKED_RESET;
		cf_tstr = CFG_PACKED_RESET;
		cf_istr = CFG_PACKED_RESET;
		cf_tsize = 1;
		cf_total = 1;
		cur_blk = 1;
		cur_off = 1;
		for (int i = 0; i < 4; i++) cur_pt[i] = 16'd1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_small_grid();
		test_saturation();
		test_degenerate();
		test_backpressure();
		test_sender_pause();
		test_random(7, 100);
		quiet = 1'b1;
		test_random(1, 60);

		if (expected_answers.size() != 0) begin
			$error("%0d answers never arrived", expected_answers.size());
			n_err++;
		end
		if (n_err == 0) $display("tb_top: done, clean");
		else $display("tb_top: done, errors");
		$finish;
	end

endmodule
